FILE: hdl/cvsu_pkg.sv
// Package for the control valve status update block: field widths, element
// kind codes, status codes, register indexes and the stage 2 flag struct.
// No dependencies.
package cvsu_pkg;

  localparam int unsigned HEAD_W  = 32;
  localparam int unsigned TOL_W   = 16;
  localparam int unsigned SUM_W   = HEAD_W + 1;  // pressure plus elevation
  localparam int unsigned CMP_W   = HEAD_W + 2;  // sum plus tolerance
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned IN_W    = 200;         // 194 bits of fields, byte padded
  localparam int unsigned OUT_W   = 8;
  localparam int unsigned CIDX_W  = 1;

  localparam logic [TOL_W-1:0] HEAD_TOL_RST = 16'd10;
  localparam logic [TOL_W-1:0] FLOW_TOL_RST = 16'd475;

  // element kinds
  localparam logic [KIND_W-1:0] KIND_CHECK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRV   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PSV   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FCV   = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_CLOSED = 2'd0;
  localparam logic [STAT_W-1:0] ST_OPEN   = 2'd1;
  localparam logic [STAT_W-1:0] ST_ACTIVE = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNUSED = 2'd3;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_HEAD_TOL = 1'b0;
  localparam logic [CIDX_W-1:0] REG_FLOW_TOL = 1'b1;

  // comparison results handed from stage 2 to stage 3
  typedef struct packed {
    logic d_gt;    // Hi - Hj > ht
    logic d_lt;    // Hi - Hj < -ht
    logic rev;     // reverse flow beyond tolerance
    logic prv_a;   // Hi < set + hj - ht
    logic prv_b;   // Hj > set + hj + ht
    logic prv_c;   // Hj < set + hj - ht
    logic psv_a;   // Hj > set + hi + ht
    logic psv_b;   // Hi < set + hi - ht
    logic psv_c;   // Hi > set + hi + ht
    logic fcv_hi;  // flow >= setting
  } cmp_flags_t;

endpackage

FILE: hdl/control_valve_status_update_top.sv
// Top level of the control valve status update block: three-stage pipeline
// from element description to new status and repair actions.
// Depends on cvsu_pkg.
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+-------------------------------
//  s_*       | in  | s_tvalid / s_tready    | s_tdata element word, s_tuser kind
//  m_*       | out | m_tvalid / m_tready    | m_tdata status and action flags
//  cfg_*     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (tolerances)
//
// One word per cycle sustained while m_tready is high; each word passes three
// registers (head sums, tolerance compares, status decode plus output register)
// before m_tvalid rises.
// Reset clears the stage valid bits and loads the default tolerances.
// A stage advances when it is empty or the stage after it advances, so a
// stall at m_tready backs up stage by stage; no word is lost or repeated.
// cfg_ready is always high; writes take effect in the next cycle.
module control_valve_status_update_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [1:0] prev_status, [33:2] start_pressure, [65:34] end_pressure,
  // [97:66] start_elevation, [129:98] end_elevation, [161:130] flow_rate,
  // [193:162] valve_setting, [199:194] zero
  input  logic [cvsu_pkg::IN_W-1:0]    s_tdata,
  // [1:0] command
  input  logic [cvsu_pkg::KIND_W-1:0]  s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [1:0] new_status, [2] status_changed, [3] zero_flow, [4] force_end_head,
  // [5] force_start_head, [6] activate_nodes, [7] recheck_nodes
  output logic [cvsu_pkg::OUT_W-1:0]   m_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cvsu_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [cvsu_pkg::TOL_W-1:0]   cfg_data
);
  import cvsu_pkg::*;

  // configuration
  logic [TOL_W-1:0] head_tol;
  logic [TOL_W-1:0] flow_tol;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_tol <= HEAD_TOL_RST;
      flow_tol <= FLOW_TOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEAD_TOL: head_tol <= cfg_data;
        REG_FLOW_TOL: flow_tol <= cfg_data;
        default: ;
      endcase
    end
  end

  // input unpack
  logic [STAT_W-1:0]        in_old;
  logic signed [HEAD_W-1:0] in_pi, in_pj, in_hi, in_hj, in_vf, in_set;

  assign in_old = s_tdata[1:0];
  assign in_pi  = s_tdata[33:2];
  assign in_pj  = s_tdata[65:34];
  assign in_hi  = s_tdata[97:66];
  assign in_hj  = s_tdata[129:98];
  assign in_vf  = s_tdata[161:130];
  assign in_set = s_tdata[193:162];

  // stage handshakes
  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  assign adv3     = !v3 || m_tready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign s_tready = adv1;

  // stage 1: head sums
  logic [KIND_W-1:0]        k1;
  logic [STAT_W-1:0]        o1;
  logic signed [SUM_W-1:0]  hs1, he1, shj1, shi1;
  logic signed [HEAD_W-1:0] vf1, set1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv1) v1 <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv1 && s_tvalid) begin
      k1   <= s_tuser;
      // unused old status code reads as closed
      o1   <= (in_old == ST_UNUSED) ? ST_CLOSED : in_old;
      hs1  <= SUM_W'(in_pi) + SUM_W'(in_hi);
      he1  <= SUM_W'(in_pj) + SUM_W'(in_hj);
      shj1 <= SUM_W'(in_set) + SUM_W'(in_hj);
      shi1 <= SUM_W'(in_set) + SUM_W'(in_hi);
      vf1  <= in_vf;
      set1 <= in_set;
    end
  end

  // stage 2: tolerance compares, all on CMP_W signed values
  logic signed [CMP_W-1:0] ht_x, ft_x;
  logic signed [CMP_W-1:0] hs_x, he_x, shj_x, shi_x, vf_x, set_x;
  cmp_flags_t              flags_d;

  assign ht_x  = $signed({{(CMP_W-TOL_W){1'b0}}, head_tol});
  assign ft_x  = $signed({{(CMP_W-TOL_W){1'b0}}, flow_tol});
  assign hs_x  = CMP_W'(hs1);
  assign he_x  = CMP_W'(he1);
  assign shj_x = CMP_W'(shj1);
  assign shi_x = CMP_W'(shi1);
  assign vf_x  = CMP_W'(vf1);
  assign set_x = CMP_W'(set1);

  always_comb begin
    flags_d.d_gt   = hs_x > he_x + ht_x;
    flags_d.d_lt   = hs_x + ht_x < he_x;
    flags_d.rev    = vf_x + ft_x < CMP_W'(0);
    flags_d.prv_a  = hs_x + ht_x < shj_x;
    flags_d.prv_b  = he_x > shj_x + ht_x;
    flags_d.prv_c  = he_x + ht_x < shj_x;
    flags_d.psv_a  = he_x > shi_x + ht_x;
    flags_d.psv_b  = hs_x + ht_x < shi_x;
    flags_d.psv_c  = hs_x > shi_x + ht_x;
    flags_d.fcv_hi = vf_x >= set_x;
  end

  logic [KIND_W-1:0] k2;
  logic [STAT_W-1:0] o2;
  cmp_flags_t        f2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv2) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      k2 <= k1;
      o2 <= o1;
      f2 <= flags_d;
    end
  end

  // stage 3: status decode and actions into the output register
  logic [STAT_W-1:0] ns;
  logic              chg;
  logic [OUT_W-1:0]  out_next;

  always_comb begin
    ns = o2;
    unique case (k2)
      KIND_CHECK: begin
        if (f2.d_gt || f2.d_lt) ns = (f2.d_lt || f2.rev) ? ST_CLOSED : ST_OPEN;
        else if (f2.rev)        ns = ST_CLOSED;
      end
      KIND_PRV: begin
        if (o2 == ST_ACTIVE) begin
          if (f2.rev)        ns = ST_CLOSED;
          else if (f2.prv_a) ns = ST_OPEN;
          else               ns = ST_ACTIVE;
        end else if (o2 == ST_OPEN) begin
          if (f2.rev)        ns = ST_CLOSED;
          else if (f2.prv_b) ns = ST_ACTIVE;
          else               ns = ST_OPEN;
        end else begin
          if (f2.d_gt && f2.prv_a)      ns = ST_OPEN;
          else if (f2.d_gt && f2.prv_c) ns = ST_ACTIVE;
          else                          ns = ST_CLOSED;
        end
      end
      KIND_PSV: begin
        if (o2 == ST_ACTIVE) begin
          if (f2.rev)        ns = ST_CLOSED;
          else if (f2.psv_a) ns = ST_OPEN;
          else               ns = ST_ACTIVE;
        end else if (o2 == ST_OPEN) begin
          if (f2.rev)        ns = ST_CLOSED;
          else if (f2.psv_b) ns = ST_ACTIVE;
          else               ns = ST_OPEN;
        end else begin
          if (f2.psv_a && f2.d_gt)      ns = ST_OPEN;
          else if (f2.psv_c && f2.d_gt) ns = ST_ACTIVE;
          else                          ns = ST_CLOSED;
        end
      end
      KIND_FCV: begin
        if (f2.d_lt || f2.rev)                ns = ST_OPEN;
        else if (o2 == ST_OPEN && f2.fcv_hi)  ns = ST_ACTIVE;
      end
      default: ;
    endcase

    chg = ns != o2;
    out_next      = '0;
    out_next[1:0] = ns;
    out_next[2]   = chg;
    if (chg) begin
      if (k2 == KIND_PSV) begin
        // sustaining valve does no node marking
        out_next[3] = ns == ST_CLOSED;
        out_next[5] = ns == ST_ACTIVE;
      end else if (ns == ST_CLOSED) begin
        out_next[3] = 1'b1;
        out_next[7] = 1'b1;
      end else begin
        out_next[6] = 1'b1;
        out_next[4] = (ns == ST_ACTIVE) && (k2 != KIND_CHECK);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv3) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2) m_tdata <= out_next;
  end

  assign m_tvalid = v3;

  // checks
  a_no_action_unchanged: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[7:3] == '0)
    else $error("action flag set on unchanged status");

  a_zero_flow_closed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[1:0] == ST_CLOSED)
    else $error("zero_flow without closed status");

  a_start_head_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5] |-> !m_tdata[4] && !m_tdata[6] && !m_tdata[7]
      && m_tdata[1:0] == ST_ACTIVE)
    else $error("force_start_head mixed with other actions");

  a_backpressure_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> v1 && v2 && v3 && !m_tready)
    else $error("input stalled with a free pipeline stage");

  a_stage_move: assert property (@(posedge clk) disable iff (rst)
    v2 && adv3 |=> v3)
    else $error("stage 2 word lost");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for control_valve_status_update_top: streams valve element words,
// predicts each new status and action set, and checks every output word.
// Depends on cvsu_pkg and the control_valve_status_update_top RTL.
module tb_top;
  import cvsu_pkg::*;

  localparam int METRE = 65536;
  localparam int MAX_I = 32'sh7fff_ffff;
  localparam int MIN_I = -2147483647 - 1;

  typedef struct {
    logic [KIND_W-1:0] command;
    logic [STAT_W-1:0] prev_status;
    int start_pressure;
    int end_pressure;
    int start_elevation;
    int end_elevation;
    int flow_rate;
    int valve_setting;
  } element_t;

  // same layout as m_tdata, lowest bit last
  typedef struct packed {
    logic recheck_nodes;
    logic activate_nodes;
    logic force_start_head;
    logic force_end_head;
    logic zero_flow;
    logic status_changed;
    logic [STAT_W-1:0] new_status;
  } status_word_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_W-1:0] s_tdata;
  logic [KIND_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [TOL_W-1:0] cfg_data;

  logic [TOL_W-1:0] head_tol = HEAD_TOL_RST;
  logic [TOL_W-1:0] flow_tol = FLOW_TOL_RST;
  status_word_t pending_status[$];
  int mismatches = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;

  control_valve_status_update_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic status_word_t predict_valve_status(element_t e);
    status_word_t r;
    longint ht, ft, elev_in, elev_out, head_in, head_out, d, setp, vf;
    logic [STAT_W-1:0] old_st, new_st;
    logic rev;
    ht = longint'(head_tol);
    ft = longint'(flow_tol);
    elev_in = longint'(e.start_elevation);
    elev_out = longint'(e.end_elevation);
    head_in = longint'(e.start_pressure) + elev_in;
    head_out = longint'(e.end_pressure) + elev_out;
    d = head_in - head_out;
    vf = longint'(e.flow_rate);
    setp = longint'(e.valve_setting);
    rev = (vf < -ft);
    old_st = (e.prev_status == ST_UNUSED) ? ST_CLOSED : e.prev_status;
    new_st = old_st;
    case (e.command)
      KIND_CHECK: begin
        if (d > ht || d < -ht) new_st = (d < -ht || rev) ? ST_CLOSED : ST_OPEN;
        else if (rev) new_st = ST_CLOSED;
      end
      KIND_PRV: begin
        if (old_st == ST_ACTIVE) begin
          if (rev) new_st = ST_CLOSED;
          else if (head_in < setp + elev_out - ht) new_st = ST_OPEN;
          else new_st = ST_ACTIVE;
        end else if (old_st == ST_OPEN) begin
          if (rev) new_st = ST_CLOSED;
          else if (head_out > setp + elev_out + ht) new_st = ST_ACTIVE;
          else new_st = ST_OPEN;
        end else begin
          if (head_in > head_out + ht && head_in < setp + elev_out - ht) new_st = ST_OPEN;
          else if (head_in > head_out + ht && head_out < setp + elev_out - ht)
            new_st = ST_ACTIVE;
          else new_st = ST_CLOSED;
        end
      end
      KIND_PSV: begin
        if (old_st == ST_ACTIVE) begin
          if (rev) new_st = ST_CLOSED;
          else if (head_out > setp + elev_in + ht) new_st = ST_OPEN;
          else new_st = ST_ACTIVE;
        end else if (old_st == ST_OPEN) begin
          if (rev) new_st = ST_CLOSED;
          else if (head_in < setp + elev_in - ht) new_st = ST_ACTIVE;
          else new_st = ST_OPEN;
        end else begin
          if (head_out > setp + elev_in + ht && head_in > head_out + ht) new_st = ST_OPEN;
          else if (head_in > setp + elev_in + ht && head_in > head_out + ht)
            new_st = ST_ACTIVE;
          else new_st = ST_CLOSED;
        end
      end
      default: begin
        if (d < -ht || rev) new_st = ST_OPEN;
        else if (old_st == ST_OPEN && vf >= setp) new_st = ST_ACTIVE;
      end
    endcase
    r = '0;
    r.new_status = new_st;
    r.status_changed = (new_st != old_st);
    if (r.status_changed) begin
      if (e.command == KIND_PSV) begin
        // sustaining valve never marks nodes
        r.zero_flow = (new_st == ST_CLOSED);
        r.force_start_head = (new_st == ST_ACTIVE);
      end else if (new_st == ST_CLOSED) begin
        r.zero_flow = 1'b1;
        r.recheck_nodes = 1'b1;
      end else begin
        r.activate_nodes = 1'b1;
        r.force_end_head = (new_st == ST_ACTIVE && e.command != KIND_CHECK);
      end
    end
    return r;
  endfunction

  function automatic element_t make_element(logic [KIND_W-1:0] kind,
                                            logic [STAT_W-1:0] old, int sp, int ep,
                                            int se, int ee, int fr, int setp);
    element_t e;
    e.command = kind;
    e.prev_status = old;
    e.start_pressure = sp;
    e.end_pressure = ep;
    e.start_elevation = se;
    e.end_elevation = ee;
    e.flow_rate = fr;
    e.valve_setting = setp;
    return e;
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mostly words placed near the decision thresholds, some pure noise.
  function automatic element_t random_element();
    element_t e;
    int span_h;
    span_h = 2 * int'(head_tol) + 3;
    e.command = 2'($urandom_range(0, 3));
    e.prev_status = ($urandom_range(0, 15) == 0) ? ST_UNUSED : 2'($urandom_range(0, 2));
    if ($urandom_range(0, 9) == 0) begin
      e.start_pressure = $urandom;
      e.end_pressure = $urandom;
      e.start_elevation = $urandom;
      e.end_elevation = $urandom;
      e.flow_rate = $urandom;
      e.valve_setting = $urandom;
      return e;
    end
    e.start_elevation = jitter(1 << 24);
    e.end_elevation = jitter(1 << 24);
    e.valve_setting = jitter(1 << 26);
    if ($urandom_range(0, 4) == 0) e.end_pressure = jitter(1 << 27);
    else e.end_pressure = e.valve_setting + jitter(span_h);
    case ($urandom_range(0, 2))
      0: e.start_pressure = e.valve_setting + jitter(span_h);
      1: e.start_pressure = e.end_pressure + e.end_elevation - e.start_elevation
                            + jitter(span_h);
      default: e.start_pressure = jitter(1 << 27);
    endcase
    case ($urandom_range(0, 3))
      0: e.flow_rate = -int'(flow_tol) + jitter(3);
      1: e.flow_rate = e.valve_setting + jitter(3);
      2: e.flow_rate = jitter(2 * int'(flow_tol) + 3);
      default: e.flow_rate = $urandom;
    endcase
    return e;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH t=%0t %s: got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Called at a falling edge; returns at the falling edge after the accept
  // with s_tvalid still high so words can go back to back.
  task automatic send_element(element_t e);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk);
    end
    s_tdata = {6'd0, e.valve_setting, e.flow_rate, e.end_elevation, e.start_elevation,
               e.end_pressure, e.start_pressure, e.prev_status};
    s_tuser = e.command;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_status = {pending_status, predict_valve_status(e)};
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    repeat (count) send_element(random_element());
  endtask

  task automatic wait_for_drain();
    s_tvalid = 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [TOL_W-1:0] value);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_HEAD_TOL) head_tol = value;
    else flow_tol = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_tolerances(logic [TOL_W-1:0] head, logic [TOL_W-1:0] flow);
    wait_for_drain();
    write_reg(REG_HEAD_TOL, head);
    write_reg(REG_FLOW_TOL, flow);
  endtask

  // Rule branches of each valve kind at the reset tolerances, plus field extremes.
  task automatic test_directed_rules();
    send_element(make_element(KIND_CHECK, ST_OPEN, 0, 5 * METRE, 0, 0, 0, 0));
    send_element(make_element(KIND_CHECK, ST_CLOSED, 5 * METRE, 0, 0, 0, 0, 0));
    send_element(make_element(KIND_CHECK, ST_OPEN, 5 * METRE, 0, 0, 0, -1000, 0));
    send_element(make_element(KIND_CHECK, ST_OPEN, 5, 0, 0, 0, -1000, 0));
    // active check valve inside the band keeps its status
    send_element(make_element(KIND_CHECK, ST_ACTIVE, 0, 0, 0, 0, 0, 0));
    send_element(make_element(KIND_PRV, ST_ACTIVE, 0, 0, 0, 0, -1000, 0));
    send_element(make_element(KIND_PRV, ST_ACTIVE, 10 * METRE, 5 * METRE, 0, 0, 0,
                              20 * METRE));
    send_element(make_element(KIND_PRV, ST_ACTIVE, 30 * METRE, 5 * METRE, 0, 0, 0,
                              20 * METRE));
    send_element(make_element(KIND_PRV, ST_OPEN, 0, 25 * METRE, 0, 0, 0, 20 * METRE));
    send_element(make_element(KIND_PRV, ST_OPEN, 0, 5 * METRE, 0, 0, 0, 20 * METRE));
    send_element(make_element(KIND_PRV, ST_CLOSED, 10 * METRE, 5 * METRE, 0, 0, 0,
                              20 * METRE));
    send_element(make_element(KIND_PRV, ST_CLOSED, 30 * METRE, 5 * METRE, 0, 0, 0,
                              20 * METRE));
    send_element(make_element(KIND_PRV, ST_CLOSED, 5 * METRE, 10 * METRE, 0, 0, 0,
                              20 * METRE));
    send_element(make_element(KIND_PSV, ST_ACTIVE, 0, 0, 0, 0, -1000, 0));
    send_element(make_element(KIND_PSV, ST_ACTIVE, 0, 30 * METRE, 0, 0, 0, 20 * METRE));
    send_element(make_element(KIND_PSV, ST_OPEN, 10 * METRE, 0, 0, 0, 0, 20 * METRE));
    send_element(make_element(KIND_PSV, ST_CLOSED, 40 * METRE, 30 * METRE, 0, 0, 0,
                              20 * METRE));
    send_element(make_element(KIND_PSV, ST_CLOSED, 30 * METRE, 10 * METRE, 0, 0, 0,
                              20 * METRE));
    send_element(make_element(KIND_FCV, ST_CLOSED, 0, 5 * METRE, 0, 0, 0, 0));
    send_element(make_element(KIND_FCV, ST_ACTIVE, 0, 0, 0, 0, -1000, 0));
    send_element(make_element(KIND_FCV, ST_OPEN, 0, 0, 0, 0, 2000, 1000));
    send_element(make_element(KIND_FCV, ST_ACTIVE, 0, 0, 0, 0, 0, 1000));
    // status code three reads as closed
    send_element(make_element(KIND_CHECK, ST_UNUSED, 5 * METRE, 0, 0, 0, 0, 0));
    send_element(make_element(KIND_PSV, ST_UNUSED, 0, 0, 0, 0, 0, 0));
    send_element(make_element(KIND_PRV, ST_ACTIVE, MAX_I, MAX_I, MAX_I, MAX_I, MAX_I,
                              MAX_I));
    send_element(make_element(KIND_FCV, ST_OPEN, MIN_I, MIN_I, MIN_I, MIN_I, MIN_I,
                              MIN_I));
  endtask

  task automatic test_tolerance_extremes();
    set_tolerances('0, '0);
    send_random(150);
    set_tolerances('1, '1);
    send_random(150);
    set_tolerances('0, '1);
    send_random(50);
    set_tolerances('1, '0);
    send_random(50);
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      if ($urandom_range(0, 1) == 0)
        set_tolerances(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      else
        set_tolerances(16'($urandom_range(0, 64)), 16'($urandom_range(0, 1024)));
      send_random(200);
    end
  endtask

  task automatic test_back_to_back();
    set_tolerances(HEAD_TOL_RST, FLOW_TOL_RST);
    idle_on = 1'b0;
    send_random(200);
  endtask

  // output side stalls in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      m_tready = 1'b0;
      stall_left = $urandom_range(1, 9) - 1;
    end else begin
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    status_word_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_status.size() == 0) begin
        report_mismatch("unexpected word", m_tdata, 0);
      end else begin
        want = pending_status.pop_front();
        if (got.new_status !== want.new_status)
          report_mismatch("new_status", got.new_status, want.new_status);
        if (got.status_changed !== want.status_changed)
          report_mismatch("status_changed", got.status_changed, want.status_changed);
        if (got.zero_flow !== want.zero_flow)
          report_mismatch("zero_flow", got.zero_flow, want.zero_flow);
        if (got.force_end_head !== want.force_end_head)
          report_mismatch("force_end_head", got.force_end_head, want.force_end_head);
        if (got.force_start_head !== want.force_start_head)
          report_mismatch("force_start_head", got.force_start_head, want.force_start_head);
        if (got.activate_nodes !== want.activate_nodes)
          report_mismatch("activate_nodes", got.activate_nodes, want.activate_nodes);
        if (got.recheck_nodes !== want.recheck_nodes)
          report_mismatch("recheck_nodes", got.recheck_nodes, want.recheck_nodes);
      end
    end
  end

  initial begin
    rst = 1'b1;
    m_tready = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_rules();
    test_tolerance_extremes();
    test_random_settings();
    test_back_to_back();
    wait_for_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("control_valve_status_update_top verification clean");
    end else begin
      $display("control_valve_status_update_top verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("control_valve_status_update_top verification failed");
    $finish;
  end

endmodule
